>>> rtl/core/hmsct_pkg.sv
// shared codes, field layout and constants of the countdown timer controller
package hmsct_pkg;

	// key codes
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_UP   = 3'd1;
	localparam logic [2:0] KEY_DN   = 3'd2;
	localparam logic [2:0] KEY_OK   = 3'd3;
	localparam logic [2:0] KEY_ESC  = 3'd4;

	// mode codes
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_EDIT  = 3'd1;
	localparam logic [2:0] MODE_RUN   = 3'd2;
	localparam logic [2:0] MODE_PAUSE = 3'd3;
	localparam logic [2:0] MODE_DONE  = 3'd4;

	// cursor codes
	localparam logic [1:0] CUR_HOURS   = 2'd0;
	localparam logic [1:0] CUR_MINUTES = 2'd1;
	localparam logic [1:0] CUR_SECONDS = 2'd2;
	localparam logic [1:0] CUR_START   = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOURS  = 1'b1;
	localparam logic [7:0] BLINK_HALF_RESET = 8'd50;
	localparam logic [4:0] MAX_HOURS_RESET  = 5'd24;

	// field widths and limits
	localparam int unsigned HOURS_W  = 5;
	localparam int unsigned MINSEC_W = 6;
	localparam int unsigned REMAIN_W = 27;
	localparam int unsigned TIME_W   = 32;
	localparam logic [MINSEC_W-1:0] MINSEC_MAX = 6'd59;
	localparam logic [REMAIN_W-1:0] MS_PER_HOUR = 27'd3600000;
	localparam logic [REMAIN_W-1:0] MS_PER_MIN  = 27'd60000;
	localparam logic [REMAIN_W-1:0] MS_PER_SEC  = 27'd1000;

	// exact reciprocal constants for the display split
	localparam logic [27:0] DIV1000_MUL = 28'd137438954;
	localparam int unsigned DIV1000_SH  = 37;
	localparam logic [18:0] DIV60_MUL   = 19'd279621;
	localparam int unsigned DIV60_SH    = 24;
	localparam logic [18:0] DIV3600_MUL = 19'd298262;
	localparam int unsigned DIV3600_SH  = 30;

	// stream word layout
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned OUT_MODE_LSB   = 0;
	localparam int unsigned OUT_CURSOR_LSB = 3;
	localparam int unsigned OUT_HOURS_LSB  = 5;
	localparam int unsigned OUT_MIN_LSB    = 10;
	localparam int unsigned OUT_SEC_LSB    = 16;
	localparam int unsigned OUT_REMAIN_LSB = 22;
	localparam int unsigned OUT_BLINK_BIT  = 49;
	localparam int unsigned OUT_EXIT_BIT   = 50;

	// state picture taken after each word
	typedef struct packed {
		logic [2:0]          mode;
		logic [1:0]          cursor;
		logic [HOURS_W-1:0]  set_hours;
		logic [MINSEC_W-1:0] set_minutes;
		logic [MINSEC_W-1:0] set_seconds;
		logic [REMAIN_W-1:0] remain;
		logic                blink;
		logic                exit_request;
	} snap_t;

endpackage

>>> rtl/core/hms_countdown_timer_controller.sv
// countdown timer controller: key handling, run timing and display split
//
//  channel  | direction | handshake                  | contents
//  ---------+-----------+----------------------------+------------------------------------
//  s_*      | in        | s_tvalid / s_tready        | one tick: page flag, key, timestamp
//  m_*      | out       | m_tvalid / m_tready        | one result word per tick
//  cfg_*    | in        | cfg_valid / cfg_ready      | register index and write data
//
//  one word can be taken every cycle while s_tready is high; the timer state updates at the accepting edge
//  its result word then passes a state snapshot register,
//  a whole-seconds stage, a minutes and hours stage, then the output register
//  a stalled output fills those four registers, then s_tready drops
//  reset is asynchronous, active low; cfg_ready is always high
module hms_countdown_timer_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// key [2:0], now_ms [34:3], zero [39:35]
	input  logic [hmsct_pkg::S_TDATA_W-1:0]       s_tdata,
	// page_active [0]
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// mode [2:0], cursor [4:3], shown_hours [9:5], shown_minutes [15:10],
	// shown_seconds [21:16], remaining_ms [48:22], blink [49],
	// exit_request [50], zero [55:51]
	output logic [hmsct_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hmsct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hmsct_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE  = hmsct_pkg::MODE_IDLE,
		ST_EDIT  = hmsct_pkg::MODE_EDIT,
		ST_RUN   = hmsct_pkg::MODE_RUN,
		ST_PAUSE = hmsct_pkg::MODE_PAUSE,
		ST_DONE  = hmsct_pkg::MODE_DONE
	} mode_t;

	localparam int unsigned HW = hmsct_pkg::HOURS_W;
	localparam int unsigned MW = hmsct_pkg::MINSEC_W;
	localparam int unsigned RW = hmsct_pkg::REMAIN_W;
	localparam int unsigned TW = hmsct_pkg::TIME_W;

	// configuration registers
	logic [7:0]    blink_half_q;
	logic [HW-1:0] max_hours_q;

	// timer state
	mode_t         mode_q, mode_n;
	logic [1:0]    cursor_q, cursor_n;
	logic [HW-1:0] set_hours_q, set_hours_n;
	logic [MW-1:0] set_minutes_q, set_minutes_n;
	logic [MW-1:0] set_seconds_q, set_seconds_n;
	logic [RW-1:0] target_q, target_n;
	logic [TW-1:0] elapsed_q, elapsed_n;
	logic [TW-1:0] start_q, start_n;
	logic [RW-1:0] remain_q, remain_n;
	logic          blink_q, blink_n;
	logic [7:0]    blink_cnt_q, blink_cnt_n;
	logic          exit_n;

	logic [2:0]    key_in;
	logic [TW-1:0] now_in;
	logic [TW-1:0] run_d;
	logic [RW-1:0] target_calc;
	logic          accept;

	// split pipeline
	logic                      v_s1, v_s2, v_s3, out_valid_q;
	logic                      rdy1, rdy2, rdy3, rdy4;
	hmsct_pkg::snap_t          snap_n, snap_s1, snap_s2, snap_s3;
	logic [54:0]               prod_sec;
	logic [36:0]               prod_min, prod_hour;
	logic [17:0]               total_s_s2, total_s_s3;
	logic [11:0]               total_min_s3;
	logic [5:0]                hours_s3;
	logic [17:0]               sec_full;
	logic [11:0]               min_full;
	logic                      timed;
	logic [HW-1:0]             shown_h;
	logic [MW-1:0]             shown_m, shown_s;
	logic [hmsct_pkg::M_TDATA_W-1:0] out_word, out_q;

	function automatic logic [HW-1:0] step_hours(input logic [HW-1:0] v,
		input logic [HW-1:0] lim, input logic up);
		logic [HW-1:0] r;
		if (up) begin
			r = (v >= lim) ? '0 : v + HW'(1);
		end else begin
			r = (v == '0) ? lim : v - HW'(1);
		end
		return r;
	endfunction

	function automatic logic [MW-1:0] step_minsec(input logic [MW-1:0] v, input logic up);
		logic [MW-1:0] r;
		if (up) begin
			r = (v >= hmsct_pkg::MINSEC_MAX) ? '0 : v + MW'(1);
		end else begin
			r = (v == '0) ? hmsct_pkg::MINSEC_MAX : v - MW'(1);
		end
		return r;
	endfunction

	assign key_in    = s_tdata[2:0];
	assign now_in    = s_tdata[34:3];
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// set time in milliseconds, constant multiplies only
	assign target_calc = RW'(set_hours_q) * hmsct_pkg::MS_PER_HOUR
		+ RW'(set_minutes_q) * hmsct_pkg::MS_PER_MIN
		+ RW'(set_seconds_q) * hmsct_pkg::MS_PER_SEC;

	// next timer state for the word at the input
	always_comb begin
		mode_n        = mode_q;
		cursor_n      = cursor_q;
		set_hours_n   = set_hours_q;
		set_minutes_n = set_minutes_q;
		set_seconds_n = set_seconds_q;
		target_n      = target_q;
		elapsed_n     = elapsed_q;
		start_n       = start_q;
		remain_n      = remain_q;
		blink_n       = blink_q;
		blink_cnt_n   = blink_cnt_q;
		exit_n        = 1'b0;
		run_d         = '0;
		if (s_tuser) begin
			if (mode_q == ST_DONE) begin
				// any real key leaves finished; target is kept
				if (key_in == hmsct_pkg::KEY_UP || key_in == hmsct_pkg::KEY_DN ||
				    key_in == hmsct_pkg::KEY_OK || key_in == hmsct_pkg::KEY_ESC) begin
					mode_n        = ST_IDLE;
					cursor_n      = hmsct_pkg::CUR_HOURS;
					set_hours_n   = '0;
					set_minutes_n = '0;
					set_seconds_n = '0;
					elapsed_n     = '0;
					start_n       = '0;
					remain_n      = '0;
				end
			end else begin
				case (key_in)
					hmsct_pkg::KEY_UP, hmsct_pkg::KEY_DN: begin
						if (mode_q == ST_IDLE) begin
							cursor_n = (key_in == hmsct_pkg::KEY_UP) ? cursor_q + 2'd1
								: cursor_q - 2'd1;
						end else if (mode_q == ST_EDIT) begin
							case (cursor_q)
								hmsct_pkg::CUR_HOURS: begin
									set_hours_n = step_hours(set_hours_q, max_hours_q,
										key_in == hmsct_pkg::KEY_UP);
								end
								hmsct_pkg::CUR_MINUTES: begin
									set_minutes_n = step_minsec(set_minutes_q,
										key_in == hmsct_pkg::KEY_UP);
								end
								hmsct_pkg::CUR_SECONDS: begin
									set_seconds_n = step_minsec(set_seconds_q,
										key_in == hmsct_pkg::KEY_UP);
								end
								default: begin
								end
							endcase
						end else if (mode_q == ST_PAUSE && key_in == hmsct_pkg::KEY_DN) begin
							mode_n    = ST_IDLE;
							elapsed_n = '0;
							start_n   = '0;
							remain_n  = '0;
						end
					end
					hmsct_pkg::KEY_OK: begin
						case (mode_q)
							ST_IDLE: begin
								if (cursor_q != hmsct_pkg::CUR_START) begin
									mode_n = ST_EDIT;
								end else begin
									mode_n   = ST_RUN;
									target_n = target_calc;
									start_n  = now_in;
								end
							end
							ST_EDIT: begin
								mode_n   = ST_IDLE;
								cursor_n = (cursor_q >= hmsct_pkg::CUR_SECONDS)
									? hmsct_pkg::CUR_HOURS : cursor_q + 2'd1;
							end
							ST_PAUSE: begin
								mode_n  = ST_RUN;
								start_n = now_in;
							end
							ST_RUN: begin
								mode_n    = ST_PAUSE;
								elapsed_n = elapsed_q + (now_in - start_q);
							end
							default: begin
							end
						endcase
					end
					hmsct_pkg::KEY_ESC: begin
						mode_n        = ST_IDLE;
						cursor_n      = hmsct_pkg::CUR_HOURS;
						target_n      = '0;
						set_hours_n   = '0;
						set_minutes_n = '0;
						set_seconds_n = '0;
						elapsed_n     = '0;
						start_n       = '0;
						remain_n      = '0;
						exit_n        = 1'b1;
					end
					default: begin
					end
				endcase
			end

			// fields above their limit fall back to zero while editing
			if (mode_n == ST_EDIT) begin
				if (set_hours_n > max_hours_q) begin
					set_hours_n = '0;
				end
				if (set_minutes_n > hmsct_pkg::MINSEC_MAX) begin
					set_minutes_n = '0;
				end
				if (set_seconds_n > hmsct_pkg::MINSEC_MAX) begin
					set_seconds_n = '0;
				end
			end else if (mode_n == ST_RUN) begin
				// time left, read as signed 32 bit
				run_d = TW'(target_n) - elapsed_n - (now_in - start_n);
				if (run_d == '0 || run_d[TW-1]) begin
					remain_n    = '0;
					mode_n      = ST_DONE;
					blink_n     = 1'b1;
					blink_cnt_n = '0;
				end else if (run_d > TW'(target_n)) begin
					remain_n = target_n;
				end else begin
					remain_n = run_d[RW-1:0];
				end
			end

			if (mode_n == ST_EDIT || mode_n == ST_PAUSE || mode_n == ST_DONE) begin
				if (blink_cnt_n < blink_half_q) begin
					blink_cnt_n = blink_cnt_n + 8'd1;
				end else begin
					blink_n     = ~blink_n;
					blink_cnt_n = '0;
				end
			end else begin
				blink_n = 1'b1;
			end
		end
	end

	// configuration and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_q  <= hmsct_pkg::BLINK_HALF_RESET;
			max_hours_q   <= hmsct_pkg::MAX_HOURS_RESET;
			mode_q        <= ST_IDLE;
			cursor_q      <= hmsct_pkg::CUR_SECONDS;
			set_hours_q   <= '0;
			set_minutes_q <= '0;
			set_seconds_q <= '0;
			target_q      <= '0;
			elapsed_q     <= '0;
			start_q       <= '0;
			remain_q      <= '0;
			blink_q       <= 1'b1;
			blink_cnt_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hmsct_pkg::CFG_BLINK_HALF: blink_half_q <= cfg_data;
					hmsct_pkg::CFG_MAX_HOURS: max_hours_q <= cfg_data[HW-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				mode_q        <= mode_n;
				cursor_q      <= cursor_n;
				set_hours_q   <= set_hours_n;
				set_minutes_q <= set_minutes_n;
				set_seconds_q <= set_seconds_n;
				target_q      <= target_n;
				elapsed_q     <= elapsed_n;
				start_q       <= start_n;
				remain_q      <= remain_n;
				blink_q       <= blink_n;
				blink_cnt_q   <= blink_cnt_n;
			end
		end
	end

	// picture of the state just written, plus this word's exit flag
	assign snap_n = '{
		mode:         mode_n,
		cursor:       cursor_n,
		set_hours:    set_hours_n,
		set_minutes:  set_minutes_n,
		set_seconds:  set_seconds_n,
		remain:       remain_n,
		blink:        blink_n,
		exit_request: exit_n
	};

	// per-stage flow control
	assign rdy4     = !out_valid_q || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= accept;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// remaining ms to whole seconds, then seconds to minutes and hours
	assign prod_sec  = 55'(snap_s1.remain) * 55'(hmsct_pkg::DIV1000_MUL);
	assign prod_min  = 37'(total_s_s2) * 37'(hmsct_pkg::DIV60_MUL);
	assign prod_hour = 37'(total_s_s2) * 37'(hmsct_pkg::DIV3600_MUL);

	always_ff @(posedge clk) begin
		if (rdy1 && accept) begin
			snap_s1 <= snap_n;
		end
		if (rdy2) begin
			snap_s2    <= snap_s1;
			total_s_s2 <= prod_sec[hmsct_pkg::DIV1000_SH +: 18];
		end
		if (rdy3) begin
			snap_s3      <= snap_s2;
			total_s_s3   <= total_s_s2;
			total_min_s3 <= prod_min[hmsct_pkg::DIV60_SH +: 12];
			hours_s3     <= prod_hour[hmsct_pkg::DIV3600_SH +: 6];
		end
		if (rdy4) begin
			out_q <= out_word;
		end
	end

	// remainders by multiply-and-subtract
	assign sec_full = total_s_s3 - 18'(total_min_s3) * 18'd60;
	assign min_full = total_min_s3 - 12'(hours_s3) * 12'd60;

	// timed modes show time left, the others show the set time
	assign timed = snap_s3.mode == hmsct_pkg::MODE_RUN || snap_s3.mode == hmsct_pkg::MODE_PAUSE
		|| snap_s3.mode == hmsct_pkg::MODE_DONE;
	assign shown_h = timed ? hours_s3[HW-1:0] : snap_s3.set_hours;
	assign shown_m = timed ? min_full[MW-1:0] : snap_s3.set_minutes;
	assign shown_s = timed ? sec_full[MW-1:0] : snap_s3.set_seconds;

	assign out_word = {5'd0, snap_s3.exit_request, snap_s3.blink, snap_s3.remain,
		shown_s, shown_m, shown_h, snap_s3.cursor, snap_s3.mode};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> rtl/core/hmsct_checker.sv
// port-level checks of the countdown timer controller, bound to the top level
module hmsct_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [hmsct_pkg::M_TDATA_W-1:0]   m_tdata
);

	logic [2:0]  mode;
	logic [1:0]  cursor;
	logic [26:0] remain;
	logic        blink;
	logic        exit_req;

	assign mode     = m_tdata[hmsct_pkg::OUT_MODE_LSB +: 3];
	assign cursor   = m_tdata[hmsct_pkg::OUT_CURSOR_LSB +: 2];
	assign remain   = m_tdata[hmsct_pkg::OUT_REMAIN_LSB +: 27];
	assign blink    = m_tdata[hmsct_pkg::OUT_BLINK_BIT];
	assign exit_req = m_tdata[hmsct_pkg::OUT_EXIT_BIT];

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// back lands in idle on the hours item
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && exit_req |-> mode == hmsct_pkg::MODE_IDLE
			&& cursor == hmsct_pkg::CUR_HOURS)
		else $error("exit request outside idle on hours");

	// finished means nothing left
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mode == hmsct_pkg::MODE_DONE |-> remain == '0)
		else $error("finished with time left");

	// no blinking in idle or running
	a_blink: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (mode == hmsct_pkg::MODE_IDLE || mode == hmsct_pkg::MODE_RUN) |-> blink)
		else $error("blink off in a steady mode");

	// editing never sits on the start item
	a_edit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mode == hmsct_pkg::MODE_EDIT |-> cursor != hmsct_pkg::CUR_START)
		else $error("editing with cursor on start");

endmodule

bind hms_countdown_timer_controller hmsct_checker u_hmsct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/tb.sv
// testbench of the countdown timer controller: key sessions checked against a predictor
`timescale 1ns / 1ps

module tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned TAIL_CYCLES    = 12;
	localparam int unsigned PHASE_TICKS    = 110;
	localparam logic [2:0]  KEY_CODE_MAX   = 3'd7;

	typedef enum logic [1:0] {OP_TICK, OP_CFG, OP_DRAIN, OP_HOLD} op_kind_t;

	// one entry of the stimulus list
	typedef struct {
		op_kind_t                          kind;
		logic                              page;
		logic [2:0]                        key;
		logic [31:0]                       now;
		logic                              rush;
		logic [hmsct_pkg::CFG_IDX_W-1:0]   reg_idx;
		logic [hmsct_pkg::CFG_DATA_W-1:0]  reg_val;
	} op_t;

	// one result word, split into its fields
	typedef struct packed {
		logic [2:0]                     mode;
		logic [1:0]                     cursor;
		logic [hmsct_pkg::HOURS_W-1:0]  hours;
		logic [hmsct_pkg::MINSEC_W-1:0] minutes;
		logic [hmsct_pkg::MINSEC_W-1:0] seconds;
		logic [hmsct_pkg::REMAIN_W-1:0] remain;
		logic                           blink;
		logic                           exit_req;
	} display_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [hmsct_pkg::S_TDATA_W-1:0]  s_tdata = '0;
	logic                             s_tuser = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [hmsct_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [hmsct_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [hmsct_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	hms_countdown_timer_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// stimulus list and expected display words
	op_t         pending[$];
	display_t    shown_q[$];
	int unsigned tick_count = 0;
	int unsigned mismatches = 0;
	logic [31:0] gen_now;

	// predictor copy of the timer state and its settings
	logic [7:0]                     cfg_blink_half = hmsct_pkg::BLINK_HALF_RESET;
	logic [4:0]                     cfg_max_hours  = hmsct_pkg::MAX_HOURS_RESET;
	logic [2:0]                     st_mode        = hmsct_pkg::MODE_IDLE;
	logic [1:0]                     st_cursor      = hmsct_pkg::CUR_SECONDS;
	logic [hmsct_pkg::HOURS_W-1:0]  st_hours       = '0;
	logic [hmsct_pkg::MINSEC_W-1:0] st_minutes     = '0;
	logic [hmsct_pkg::MINSEC_W-1:0] st_seconds     = '0;
	logic [hmsct_pkg::REMAIN_W-1:0] st_target      = '0;
	logic [31:0]                    st_elapsed     = '0;
	logic [31:0]                    st_start       = '0;
	logic [hmsct_pkg::REMAIN_W-1:0] st_remain      = '0;
	logic                           st_blink       = 1'b1;
	logic [7:0]                     st_blink_cnt   = '0;

	// driver and receiver bookkeeping
	op_t         tx_op;
	int unsigned tx_wait = 0;
	bit          tx_burst = 1'b0;
	int unsigned rx_wait = 0;
	bit          rx_burst = 1'b0;
	logic        hold_start = 1'b0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;

	// ---------------------------------------------------------------- predictor

	function automatic logic [5:0] step_field(logic [5:0] v, logic [5:0] lim, logic up);
		if (up)
			return (v >= lim) ? 6'd0 : v + 6'd1;
		return (v == 6'd0) ? lim : v - 6'd1;
	endfunction

	function automatic void clear_timing();
		st_elapsed = '0;
		st_start   = '0;
		st_remain  = '0;
	endfunction

	function automatic void clear_setting();
		st_hours   = '0;
		st_minutes = '0;
		st_seconds = '0;
	endfunction

	// one tick: key handling, then run update, then blink, then the display split
	function automatic display_t advance_timer(logic page, logic [2:0] key, logic [31:0] now);
		display_t    r;
		logic        exit_r;
		logic        up;
		logic [31:0] d;
		logic [31:0] target32;
		exit_r = 1'b0;
		if (page) begin
			if (st_mode == hmsct_pkg::MODE_DONE) begin
				// any real key leaves finished, back included, with no exit request
				if (key >= hmsct_pkg::KEY_UP && key <= hmsct_pkg::KEY_ESC) begin
					st_mode   = hmsct_pkg::MODE_IDLE;
					st_cursor = hmsct_pkg::CUR_HOURS;
					clear_setting();
					clear_timing();
				end
			end else begin
				case (key)
					hmsct_pkg::KEY_UP, hmsct_pkg::KEY_DN: begin
						up = (key == hmsct_pkg::KEY_UP);
						if (st_mode == hmsct_pkg::MODE_IDLE) begin
							st_cursor = up ? st_cursor + 2'd1 : st_cursor - 2'd1;
						end else if (st_mode == hmsct_pkg::MODE_EDIT) begin
							case (st_cursor)
								hmsct_pkg::CUR_HOURS: st_hours = 5'(step_field(
									{1'b0, st_hours}, {1'b0, cfg_max_hours}, up));
								hmsct_pkg::CUR_MINUTES: st_minutes = step_field(st_minutes,
									hmsct_pkg::MINSEC_MAX, up);
								hmsct_pkg::CUR_SECONDS: st_seconds = step_field(st_seconds,
									hmsct_pkg::MINSEC_MAX, up);
								default: ;
							endcase
						end else if (st_mode == hmsct_pkg::MODE_PAUSE && !up) begin
							st_mode = hmsct_pkg::MODE_IDLE;
							clear_timing();
						end
					end
					hmsct_pkg::KEY_OK: begin
						if (st_mode == hmsct_pkg::MODE_IDLE
								&& st_cursor != hmsct_pkg::CUR_START) begin
							st_mode = hmsct_pkg::MODE_EDIT;
						end else if (st_mode == hmsct_pkg::MODE_EDIT) begin
							st_mode   = hmsct_pkg::MODE_IDLE;
							st_cursor = (st_cursor >= hmsct_pkg::CUR_SECONDS)
								? hmsct_pkg::CUR_HOURS : st_cursor + 2'd1;
						end else if (st_mode == hmsct_pkg::MODE_IDLE) begin
							st_mode   = hmsct_pkg::MODE_RUN;
							target32  = st_hours * hmsct_pkg::MS_PER_HOUR
								+ st_minutes * hmsct_pkg::MS_PER_MIN
								+ st_seconds * hmsct_pkg::MS_PER_SEC;
							st_target = target32[hmsct_pkg::REMAIN_W-1:0];
							st_start  = now;
						end else if (st_mode == hmsct_pkg::MODE_PAUSE) begin
							st_mode  = hmsct_pkg::MODE_RUN;
							st_start = now;
						end else if (st_mode == hmsct_pkg::MODE_RUN) begin
							st_mode    = hmsct_pkg::MODE_PAUSE;
							st_elapsed = st_elapsed + (now - st_start);
						end
					end
					hmsct_pkg::KEY_ESC: begin
						st_mode   = hmsct_pkg::MODE_IDLE;
						st_cursor = hmsct_pkg::CUR_HOURS;
						st_target = '0;
						clear_setting();
						clear_timing();
						exit_r = 1'b1;
					end
					default: ;
				endcase
			end

			if (st_mode == hmsct_pkg::MODE_EDIT) begin
				// values left above a lowered limit fall back to zero
				if (st_hours > cfg_max_hours)
					st_hours = '0;
				if (st_minutes > hmsct_pkg::MINSEC_MAX)
					st_minutes = '0;
				if (st_seconds > hmsct_pkg::MINSEC_MAX)
					st_seconds = '0;
			end else if (st_mode == hmsct_pkg::MODE_RUN) begin
				// signed distance to the target, timestamps wrap modulo 2^32
				d = {5'd0, st_target} - st_elapsed - (now - st_start);
				if (d == 32'd0 || d[31]) begin
					st_remain    = '0;
					st_mode      = hmsct_pkg::MODE_DONE;
					st_blink     = 1'b1;
					st_blink_cnt = '0;
				end else begin
					st_remain = (d > {5'd0, st_target}) ? st_target
						: d[hmsct_pkg::REMAIN_W-1:0];
				end
			end

			if (st_mode == hmsct_pkg::MODE_EDIT || st_mode == hmsct_pkg::MODE_PAUSE
					|| st_mode == hmsct_pkg::MODE_DONE) begin
				if (st_blink_cnt < cfg_blink_half) begin
					st_blink_cnt = st_blink_cnt + 8'd1;
				end else begin
					st_blink     = ~st_blink;
					st_blink_cnt = '0;
				end
			end else begin
				st_blink = 1'b1;
			end
		end

		r.mode   = st_mode;
		r.cursor = st_cursor;
		if (st_mode == hmsct_pkg::MODE_RUN || st_mode == hmsct_pkg::MODE_PAUSE
				|| st_mode == hmsct_pkg::MODE_DONE) begin
			r.hours   = 5'(st_remain / hmsct_pkg::MS_PER_HOUR);
			r.minutes = 6'((st_remain / hmsct_pkg::MS_PER_MIN) % 60);
			r.seconds = 6'((st_remain / hmsct_pkg::MS_PER_SEC) % 60);
		end else begin
			r.hours   = st_hours;
			r.minutes = st_minutes;
			r.seconds = st_seconds;
		end
		r.remain   = st_remain;
		r.blink    = st_blink;
		r.exit_req = exit_r;
		return r;
	endfunction

	function automatic void write_setting(logic [hmsct_pkg::CFG_IDX_W-1:0] idx,
		logic [hmsct_pkg::CFG_DATA_W-1:0] val);
		if (idx == hmsct_pkg::CFG_BLINK_HALF)
			cfg_blink_half = val;
		else if (idx == hmsct_pkg::CFG_MAX_HOURS)
			cfg_max_hours = val[4:0];
	endfunction

	// wait before the next word; bursts switch the waits off for a stretch
	function automatic int unsigned draw_gap(inout bit burst);
		if ($urandom_range(0, 29) == 0)
			burst = ~burst;
		return burst ? 0 : $urandom_range(0, 10);
	endfunction

	// ---------------------------------------------------------------- stimulus list

	task automatic push_tick(logic page, logic [2:0] key, logic [31:0] advance, logic rush);
		op_t op;
		gen_now    = gen_now + advance;
		op.kind    = OP_TICK;
		op.page    = page;
		op.key     = key;
		op.now     = gen_now;
		op.rush    = rush;
		op.reg_idx = '0;
		op.reg_val = '0;
		pending.push_back(op);
		tick_count++;
	endtask

	task automatic push_ctrl(op_kind_t kind, logic [hmsct_pkg::CFG_IDX_W-1:0] idx,
		logic [hmsct_pkg::CFG_DATA_W-1:0] val);
		op_t op;
		op.kind    = kind;
		op.page    = 1'b0;
		op.key     = hmsct_pkg::KEY_NONE;
		op.now     = '0;
		op.rush    = 1'b0;
		op.reg_idx = idx;
		op.reg_val = val;
		pending.push_back(op);
	endtask

	task automatic push_plain(logic [2:0] key);
		push_tick(1'b1, key, $urandom_range(0, 300), 1'b0);
	endtask

	// hidden page, unknown key codes, or a key at an arbitrary timestamp
	task automatic push_noise();
		case ($urandom_range(0, 2))
			0: push_tick(1'b0, 3'($urandom_range(0, 7)), $urandom_range(0, 1000), 1'b0);
			1: push_tick(1'b1, 3'($urandom_range(hmsct_pkg::KEY_ESC + 1, KEY_CODE_MAX)),
				$urandom_range(0, 1000), 1'b0);
			default: begin
				gen_now = $urandom;
				push_tick(1'b1, 3'($urandom_range(0, 7)), 32'd0, 1'b0);
			end
		endcase
	endtask

	task automatic push_key(logic [2:0] key);
		if ($urandom_range(0, 24) == 0)
			push_noise();
		push_plain(key);
	endtask

	// set a time field by field, start it, then let it run with pauses and jumps
	task automatic push_session();
		logic [2:0]  dir;
		int unsigned n;
		int unsigned r;
		int unsigned f;
		push_key(hmsct_pkg::KEY_ESC);
		for (f = 0; f < 3; f++) begin
			push_key(hmsct_pkg::KEY_OK);
			dir = ($urandom_range(0, 3) == 0) ? hmsct_pkg::KEY_DN : hmsct_pkg::KEY_UP;
			case (f)
				0: n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
				1: n = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 62) :
					(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
				default: n = $urandom_range(0, 12);
			endcase
			repeat (n) push_key(dir);
			push_key(hmsct_pkg::KEY_OK);
		end
		// cursor is back on hours, one step down lands on start
		push_key(hmsct_pkg::KEY_DN);
		push_key(hmsct_pkg::KEY_OK);
		repeat ($urandom_range(5, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				push_key(hmsct_pkg::KEY_OK);
			else if (r < 11)
				push_key(hmsct_pkg::KEY_DN);
			else if (r < 13)
				push_key(hmsct_pkg::KEY_UP);
			else if (r < 16)
				push_tick(1'b1, hmsct_pkg::KEY_NONE, $urandom_range(100000, 90000000), 1'b0);
			else
				push_tick(1'b1, hmsct_pkg::KEY_NONE, $urandom_range(0, 1500), 1'b0);
		end
		if ($urandom_range(0, 1))
			push_key(3'($urandom_range(hmsct_pkg::KEY_UP, hmsct_pkg::KEY_ESC)));
	endtask

	// hours at the old limit, new settings, then edit hours so a lowered limit clears them
	task automatic push_phase(logic [7:0] half, logic [4:0] maxh, bit with_hold);
		int unsigned stop_at;
		push_plain(hmsct_pkg::KEY_ESC);
		push_plain(hmsct_pkg::KEY_OK);
		push_plain(hmsct_pkg::KEY_DN);
		push_plain(hmsct_pkg::KEY_OK);
		push_ctrl(OP_DRAIN, '0, '0);
		push_ctrl(OP_CFG, hmsct_pkg::CFG_BLINK_HALF, half);
		push_ctrl(OP_CFG, hmsct_pkg::CFG_MAX_HOURS, {3'd0, maxh});
		push_plain(hmsct_pkg::KEY_DN);
		push_plain(hmsct_pkg::KEY_OK);
		push_plain(hmsct_pkg::KEY_OK);
		if (with_hold) begin
			// receiver holds off while back-to-back words fill the pipeline
			push_ctrl(OP_HOLD, '0, '0);
			repeat (30) push_tick(1'b1, 3'($urandom_range(0, 4)), $urandom_range(0, 1500), 1'b1);
		end
		stop_at = tick_count + PHASE_TICKS;
		while (tick_count < stop_at) begin
			push_session();
			if ($urandom_range(0, 7) == 0)
				push_ctrl(OP_DRAIN, '0, '0);
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin : tx_side
		logic tv;
		logic cv;
		logic hs;
		tv = s_tvalid;
		cv = cfg_valid;
		hs = 1'b0;
		if (arst_n) begin
			// word taken: predict its result right away
			if (s_tvalid && s_tready) begin
				shown_q.push_back(advance_timer(tx_op.page, tx_op.key, tx_op.now));
				tv = 1'b0;
				tx_wait = tx_op.rush ? 0 : draw_gap(tx_burst);
			end
			if (cfg_valid && cfg_ready) begin
				write_setting(tx_op.reg_idx, tx_op.reg_val);
				cv = 1'b0;
			end
			if (!tv && !cv && pending.size() != 0) begin
				if (tx_wait != 0) begin
					tx_wait--;
				end else begin
					case (pending[0].kind)
						OP_TICK: begin
							tx_op = pending.pop_front();
							s_tdata <= {{(hmsct_pkg::S_TDATA_W-35){1'b0}}, tx_op.now, tx_op.key};
							s_tuser <= tx_op.page;
							tv = 1'b1;
						end
						OP_CFG: begin
							// settings change only once every result is out
							if (shown_q.size() == 0) begin
								tx_op = pending.pop_front();
								cfg_index <= tx_op.reg_idx;
								cfg_data  <= tx_op.reg_val;
								cv = 1'b1;
							end
						end
						OP_DRAIN: begin
							if (shown_q.size() == 0)
								void'(pending.pop_front());
						end
						default: begin
							void'(pending.pop_front());
							hs = 1'b1;
						end
					endcase
				end
			end
		end
		s_tvalid   <= tv;
		cfg_valid  <= cv;
		hold_start <= hs;
	end

	// ---------------------------------------------------------------- receiver

	// long hold-off, counted on its own
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin : rx_side
		int unsigned n;
		n = rx_wait;
		if (m_tvalid && m_tready)
			n = draw_gap(rx_burst);
		else if (n != 0)
			n--;
		rx_wait = n;
		m_tready <= arst_n && n == 0 && hold_left == 0 && !hold_start;
	end

	// ---------------------------------------------------------------- result check

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		display_t got;
		display_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mode     = m_tdata[hmsct_pkg::OUT_MODE_LSB +: 3];
			got.cursor   = m_tdata[hmsct_pkg::OUT_CURSOR_LSB +: 2];
			got.hours    = m_tdata[hmsct_pkg::OUT_HOURS_LSB +: hmsct_pkg::HOURS_W];
			got.minutes  = m_tdata[hmsct_pkg::OUT_MIN_LSB +: hmsct_pkg::MINSEC_W];
			got.seconds  = m_tdata[hmsct_pkg::OUT_SEC_LSB +: hmsct_pkg::MINSEC_W];
			got.remain   = m_tdata[hmsct_pkg::OUT_REMAIN_LSB +: hmsct_pkg::REMAIN_W];
			got.blink    = m_tdata[hmsct_pkg::OUT_BLINK_BIT];
			got.exit_req = m_tdata[hmsct_pkg::OUT_EXIT_BIT];
			if (shown_q.size() == 0) begin
				$error("result word %h with no expected result waiting", m_tdata);
				mismatches++;
			end else begin
				want = shown_q.pop_front();
				check_field("mode", want.mode, got.mode);
				check_field("cursor", want.cursor, got.cursor);
				check_field("shown_hours", want.hours, got.hours);
				check_field("shown_minutes", want.minutes, got.minutes);
				check_field("shown_seconds", want.seconds, got.seconds);
				check_field("remaining_ms", want.remain, got.remain);
				check_field("blink", want.blink, got.blink);
				check_field("exit_request", want.exit_req, got.exit_req);
			end
		end
	end

	// no handshake for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- test sequence

	initial begin
		// start just below the timestamp wrap
		gen_now = 32'hFFFF_FC00;

		// directed part at reset settings
		push_tick(1'b0, hmsct_pkg::KEY_OK, 32'd10, 1'b0);   // hidden page holds state
		push_plain(KEY_CODE_MAX);                            // unknown key
		push_plain(hmsct_pkg::KEY_UP);                       // seconds -> start
		push_plain(hmsct_pkg::KEY_UP);                       // start -> hours, cursor wrap
		push_plain(hmsct_pkg::KEY_DN);                       // hours -> start
		push_plain(hmsct_pkg::KEY_OK);                       // zero target finishes at once
		push_plain(hmsct_pkg::KEY_NONE);
		push_plain(hmsct_pkg::KEY_ESC);                      // leaves finished, no exit
		push_plain(hmsct_pkg::KEY_OK);                       // edit hours
		push_plain(hmsct_pkg::KEY_DN);                       // 0 -> max
		push_plain(hmsct_pkg::KEY_UP);                       // max -> 0
		push_plain(hmsct_pkg::KEY_DN);
		push_plain(hmsct_pkg::KEY_OK);
		push_plain(hmsct_pkg::KEY_OK);                       // edit minutes
		push_plain(hmsct_pkg::KEY_DN);                       // 0 -> 59
		push_plain(hmsct_pkg::KEY_UP);                       // 59 -> 0
		push_plain(hmsct_pkg::KEY_DN);
		push_plain(hmsct_pkg::KEY_OK);
		push_plain(hmsct_pkg::KEY_OK);                       // edit seconds
		push_plain(hmsct_pkg::KEY_UP);
		push_plain(hmsct_pkg::KEY_OK);
		push_plain(hmsct_pkg::KEY_DN);                       // cursor to start
		push_plain(hmsct_pkg::KEY_OK);                       // 24:59:01 target runs
		push_tick(1'b1, hmsct_pkg::KEY_NONE, 32'd0 - 32'd5000, 1'b0);  // clock steps back
		push_plain(hmsct_pkg::KEY_OK);                       // pause
		push_plain(hmsct_pkg::KEY_DN);                       // down in pause resets
		push_plain(hmsct_pkg::KEY_ESC);                      // exit request

		// random part over several settings, extremes first
		push_phase(8'd1, 5'd1, 1'b0);
		push_phase(8'd255, 5'd24, 1'b1);
		push_phase(8'($urandom_range(2, 254)), 5'($urandom_range(2, 23)), 1'b0);
		push_phase(hmsct_pkg::BLINK_HALF_RESET, hmsct_pkg::MAX_HOURS_RESET, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending.size() != 0 || s_tvalid || cfg_valid || shown_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
